// File: rtl/mse_pkg.sv
// ============================================================================
// Mean squared error reducer package
// Shared types, widths and codes for the front end, job queue and back end.
// ============================================================================
package mse_pkg;

    localparam int DATA_W      = 16;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int SQ_W        = 2 * DATA_W;
    localparam int SUM_W       = 48;
    localparam int COUNT_W     = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [COUNT_W-1:0] MAX_ELEMENTS = COUNT_W'(65536);
    localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};

    localparam logic [1:0] MODE_PER_ELEMENT = 2'd0;
    localparam logic [1:0] MODE_MEAN        = 2'd1;
    localparam logic [1:0] MODE_SUM         = 2'd2;
    localparam logic [1:0] MODE_RESET       = MODE_MEAN;

    typedef struct packed {
        logic signed [DATA_W-1:0] predicted;
        logic signed [DATA_W-1:0] expected;
        logic                     final_element;
    } mse_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] loss_value;
        logic             final_result;
    } mse_out_t;

    typedef struct packed {
        logic               divide;
        logic [SUM_W-1:0]   value;
        logic [COUNT_W-1:0] count;
        logic               final_result;
    } mse_job_t;

endpackage

// File: rtl/mse_front.sv
// ============================================================================
// Mean squared error front end
// Accepts transactions, squares the difference, accumulates and issues jobs.
// ============================================================================
module mse_front
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic     in_valid,
    output logic     in_ready,
    input  mse_in_t  in_data,
    output logic     job_valid,
    input  logic     job_full,
    output mse_job_t job
);

    logic [1:0]         mode_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [SQ_W-1:0]    s1_sq_reg;
    logic               s1_last_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               s1_adv;
    logic               accept;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]  mag_full;
    logic [DATA_W-1:0]  mag;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_acc;
    logic [COUNT_W-1:0] count_acc;

    assign s1_adv   = s1_valid_reg && !job_full;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign diff     = DIFF_W'(in_data.predicted) - DIFF_W'(in_data.expected);
    assign mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    assign mag      = mag_full[DATA_W-1:0];

    assign sum_wide  = {1'b0, sum_reg} + (SUM_W+1)'(s1_sq_reg);
    assign sum_acc   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign count_acc = (count_reg < MAX_ELEMENTS) ? count_reg + COUNT_W'(1) : count_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        sum_next   = sum_reg;
        count_next = count_reg;
        if (s1_adv)
        begin
            if (s1_last_reg)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else if (mode_reg != MODE_PER_ELEMENT)
            begin
                sum_next   = sum_acc;
                count_next = count_acc;
            end
        end

        job_valid        = s1_adv && ((mode_reg == MODE_PER_ELEMENT) || s1_last_reg);
        job.divide       = (mode_reg == MODE_MEAN);
        job.value        = (mode_reg == MODE_PER_ELEMENT) ? SUM_W'(s1_sq_reg) : sum_acc;
        job.count        = count_acc;
        job.final_result = s1_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_RESET;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg   <= mag * mag;
            s1_last_reg <= in_data.final_element;
        end
    end

endmodule

// File: rtl/mse_queue.sv
// ============================================================================
// Mean squared error job queue
// Short first-in first-out buffer of jobs between the front and back ends.
// ============================================================================
module mse_queue
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mse_job_t push_job,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output mse_job_t head_job
);

    mse_job_t               entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Job queue count exceeds its depth.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("Job pushed into a full queue without a pop.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QUEUE_CNT_W'(1)))
        else $error("Job queue count did not follow a push.");

endmodule

// File: rtl/mse_back.sv
// ============================================================================
// Mean squared error back end
// Executes jobs: passes values through or divides the sum by the count.
// ============================================================================
module mse_back
    import mse_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    input  mse_job_t job,
    output logic     job_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output mse_out_t out_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mse_out_t             out_data_reg;
    logic [SUM_W-1:0]     div_q_reg;
    logic [COUNT_W-1:0]   div_r_reg;
    logic [COUNT_W-1:0]   div_d_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     trial_diff;
    logic                 trial_ge;
    logic                 out_free;
    logic                 load_direct;
    logic                 load_div;
    logic                 start_div;

    assign out_free   = !out_valid_reg || out_ready;
    assign trial      = {div_r_reg, div_q_reg[SUM_W-1]};
    assign trial_diff = trial - {1'b0, div_d_reg};
    assign trial_ge   = (trial >= {1'b0, div_d_reg});

    always_comb
    begin
        state_next  = state_reg;
        load_direct = 1'b0;
        load_div    = 1'b0;
        start_div   = 1'b0;
        job_pop     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job.divide)
                    begin
                        job_pop    = 1'b1;
                        start_div  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else if (out_free)
                    begin
                        job_pop     = 1'b1;
                        load_direct = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_div   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_direct || load_div)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            div_q_reg   <= job.value;
            div_r_reg   <= '0;
            div_d_reg   <= job.count;
            div_cnt_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            div_q_reg   <= {div_q_reg[SUM_W-2:0], trial_ge};
            div_r_reg   <= trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end

        if (load_direct)
        begin
            out_data_reg.loss_value   <= job.value;
            out_data_reg.final_result <= job.final_result;
        end
        else if (load_div)
        begin
            out_data_reg.loss_value   <= div_q_reg;
            out_data_reg.final_result <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV || state_reg == ST_HOLD))
        else $error("Divider left its run before holding the quotient.");

    assert property (@(posedge clk) disable iff (!rst_n)
        start_div |=> (div_d_reg != '0))
        else $error("Mean job started with a zero element count.");

endmodule

// File: rtl/mean_squared_error_reducer.sv
// ============================================================================
// Mean squared error reducer
// Squares prediction/target differences and gives squares, sums or means.
// ============================================================================
// One transaction is accepted per cycle while the job queue has room. The
// front end registers the square of each difference and, outside per-element
// mode, folds it into a saturating 48-bit sum. A per-element or sum result
// passes through the job queue into the registered output. A mean result runs
// through the back end's shift-subtract divider, one quotient bit a cycle, and
// waits there until the output register is free. A four-entry job queue lets
// the front end keep accepting elements meanwhile; when the divider or a
// stalled output holds the queue and it fills, the input stalls.
// ============================================================================
module mean_squared_error_reducer
    import mse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  mse_in_t    in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output mse_out_t   out_data
);

    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    mse_job_t push_job;
    mse_job_t head_job;

    mse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (push),
        .job_full  (full),
        .job       (push_job)
    );

    mse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    mse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head_job),
        .job_pop   (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: dv/testbench.sv
// ============================================================================
// Mean squared error reducer testbench
// Streams prediction/target pairs through every reduction mode, including
// mid-tensor mode changes and full-scale operands, under random valid and
// ready gaps and one long output stall. Each result is checked field by
// field against a cycle-free model of the squares, sums and means.
// ============================================================================
module testbench;
    import mse_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] Q_MAX     = 16'h7FFF;
    localparam logic [DATA_W-1:0] Q_MIN     = 16'h8000;
    localparam logic [DATA_W-1:0] Q_ONE     = 16'h0100;
    localparam logic [DATA_W-1:0] Q_NEG_ONE = 16'hFF00;
    localparam logic [DATA_W-1:0] Q_LSB     = 16'h0001;
    localparam logic [DATA_W-1:0] Q_NEG_LSB = 16'hFFFF;

    localparam int SETTLE_CYCLES     = 64;
    localparam int HOLD_CYCLES       = 300;
    localparam int ITEMS_PER_SEGMENT = 56;
    localparam int TIMEOUT_CYCLES    = 2000000;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = MODE_RESET;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    mse_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    mse_out_t out_data;

    mse_in_t  queued_elements[$];
    mse_out_t pending_losses[$];

    logic [1:0]         mode_shadow   = MODE_RESET;
    logic [SUM_W-1:0]   square_sum    = '0;
    logic [COUNT_W-1:0] element_count = '0;

    logic [1:0] mode_cycle[4] = '{MODE_PER_ELEMENT, MODE_MEAN, MODE_SUM, MODE_UNUSED};

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_trigger   = 1'b0;
    bit hold_seen      = 1'b0;
    int hold_left      = 0;
    int failures       = 0;
    int accepted_count = 0;
    int result_count   = 0;

    mean_squared_error_reducer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic bit reduce_element(input mse_in_t element, output mse_out_t loss);
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        magnitude;
        logic [SQ_W-1:0]          square;
        logic [SUM_W:0]           widened;
        diff = $signed({element.predicted[DATA_W-1], element.predicted})
             - $signed({element.expected[DATA_W-1], element.expected});
        magnitude = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        square = SQ_W'(magnitude) * SQ_W'(magnitude);
        loss = '0;
        if (mode_shadow == MODE_PER_ELEMENT)
        begin
            loss.loss_value   = SUM_W'(square);
            loss.final_result = element.final_element;
            if (element.final_element)
            begin
                square_sum    = '0;
                element_count = '0;
            end
            return 1'b1;
        end
        widened = {1'b0, square_sum} + (SUM_W+1)'(square);
        square_sum = widened[SUM_W] ? SUM_MAX : widened[SUM_W-1:0];
        if (element_count < MAX_ELEMENTS)
            element_count = element_count + COUNT_W'(1);
        if (!element.final_element)
            return 1'b0;
        if (mode_shadow == MODE_MEAN)
            loss.loss_value = square_sum / SUM_W'(element_count);
        else
            loss.loss_value = square_sum;
        loss.final_result = 1'b1;
        square_sum    = '0;
        element_count = '0;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : driver
        mse_out_t loss;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                accepted_count++;
                if (reduce_element(in_data, loss))
                    pending_losses.push_back(loss);
            end
            if (!in_valid || in_ready)
            begin
                if (queued_elements.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= queued_elements.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : receiver
        if (rst_n)
        begin
            if (hold_trigger != hold_seen)
            begin
                hold_seen = hold_trigger;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        mse_out_t wanted;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_losses.size() == 0)
            begin
                $error("unexpected transaction: loss_value %0d final_result %0d",
                       out_data.loss_value, out_data.final_result);
                failures++;
            end
            else
            begin
                wanted = pending_losses.pop_front();
                if (out_data.loss_value !== wanted.loss_value)
                begin
                    $error("loss_value: expected %0d, actual %0d",
                           wanted.loss_value, out_data.loss_value);
                    failures++;
                end
                if (out_data.final_result !== wanted.final_result)
                begin
                    $error("final_result: expected %0d, actual %0d",
                           wanted.final_result, out_data.final_result);
                    failures++;
                end
            end
        end
    end

    task automatic push_element(input logic [DATA_W-1:0] predicted,
                                input logic [DATA_W-1:0] expected, input bit last);
        mse_in_t element;
        element.predicted     = predicted;
        element.expected      = expected;
        element.final_element = last;
        queued_elements.push_back(element);
    endtask

    task automatic wait_idle();
        while (queued_elements.size() != 0 || in_valid || pending_losses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge clk);
        cfg_we      <= 1'b0;
        mode_shadow  = mode;
    endtask

    function automatic logic [DATA_W-1:0] random_sample();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic queue_tensor(input int length, input bit leave_open);
        logic [DATA_W-1:0] predicted;
        logic [DATA_W-1:0] expected;
        for (int i = 0; i < length; i++)
        begin
            predicted = random_sample();
            if ($urandom_range(2) == 0)
                expected = predicted + DATA_W'($urandom_range(15));
            else
                expected = random_sample();
            push_element(predicted, expected, (i == length - 1) && !leave_open);
        end
    endtask

    task automatic run_segment(input logic [1:0] mode);
        int queued;
        int length;
        write_mode(mode);
        queued = 0;
        while (queued < ITEMS_PER_SEGMENT)
        begin
            if ($urandom_range(7) == 0)
                length = $urandom_range(13, 120);
            else
                length = $urandom_range(1, 12);
            queue_tensor(length, 1'b0);
            queued += length;
        end
        if ($urandom_range(3) == 0)
            queue_tensor($urandom_range(1, 6), 1'b1);
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_idle);
        int start;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        start = $urandom_range(3);
        for (int k = 0; k < 4; k++)
            run_segment(mode_cycle[(start + k) % 4]);
    endtask

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_element(Q_MAX, Q_MIN, 1'b1);
        push_element(Q_MIN, Q_MAX, 1'b0);
        push_element('0, '0, 1'b0);
        push_element(Q_LSB, Q_NEG_LSB, 1'b1);
        push_element(Q_MIN, Q_MIN, 1'b0);
        push_element(Q_ONE, '0, 1'b0);
        write_mode(MODE_SUM);
        push_element(Q_MAX, '0, 1'b1);
        push_element(Q_MIN, Q_ONE, 1'b0);
        write_mode(MODE_PER_ELEMENT);
        push_element(Q_NEG_LSB, Q_LSB, 1'b0);
        push_element(Q_MAX, Q_MIN, 1'b1);
        push_element('0, Q_MIN, 1'b0);
        push_element(Q_MIN, '0, 1'b1);
        write_mode(MODE_UNUSED);
        push_element(Q_ONE, Q_NEG_ONE, 1'b0);
        push_element(Q_MAX, Q_MIN, 1'b1);
        push_element(Q_LSB, '0, 1'b1);
        write_mode(MODE_MEAN);
        push_element(Q_ONE, '0, 1'b0);
        push_element('0, '0, 1'b0);
        push_element('0, '0, 1'b1);

        run_phase(33, 64);
        run_phase(64, 33);
        run_phase(0, 0);

        write_mode(MODE_PER_ELEMENT);
        hold_trigger = ~hold_trigger;
        queue_tensor(48, 1'b0);

        wait_idle();
        $display("Checked %0d results from %0d transactions in all four reduction modes,",
                 result_count, accepted_count);
        $display("including mode changes mid-tensor and a long output stall.");
        if (failures == 0)
            $display("mean_squared_error_reducer regression: pass");
        else
            $display("mean_squared_error_reducer regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("mean_squared_error_reducer regression: fail");
        $finish;
    end

endmodule
